>>> hdl/clcd_pkg.sv
// shared types and constants for the character lcd write sequencer
package clcd_pkg;

  // request kinds
  localparam logic [1:0] OP_CMD    = 2'd0;
  localparam logic [1:0] OP_CHAR   = 2'd1;
  localparam logic [1:0] OP_CURSOR = 2'd2;
  localparam logic [1:0] OP_NUM    = 2'd3;

  // cursor address offsets per row and the set-address command bit
  localparam logic [7:0] ROW0_OFFSET = 8'h00;
  localparam logic [7:0] ROW1_OFFSET = 8'h40;
  localparam logic [7:0] ROW2_OFFSET = 8'h14;
  localparam logic [7:0] ROW3_OFFSET = 8'h54;
  localparam logic [7:0] SET_ADDR_CMD = 8'h80;

  // divide by ten as multiply by reciprocal, exact for 16-bit inputs
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  // upper nibble of an ascii digit
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // hold times in ms
  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_SHORT = 2'd1;
  localparam logic [1:0] WAIT_LONG  = 2'd2;

  // steps within one enable pulse
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_done;
    logic last;
  } stat_t;

endpackage

>>> hdl/clcd_ctrl.sv
// controller state machine for the character lcd write sequencer
module clcd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  output logic               out_valid,
  input  logic               out_ready,
  output clcd_pkg::cmd_t     cmd,
  input  clcd_pkg::stat_t    stat
);

  clcd_pkg::state_t state, state_next;
  logic out_valid_next;
  logic slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= clcd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    slot_free  = !out_valid || out_ready;
    case (state)
      clcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = (operation == clcd_pkg::OP_NUM) ? clcd_pkg::ST_CONV
                                                       : clcd_pkg::ST_EMIT;
        end
      end
      clcd_pkg::ST_CONV: begin
        // one decimal digit per cycle
        cmd.conv = 1'b1;
        if (stat.conv_done) begin
          state_next = clcd_pkg::ST_EMIT;
        end
      end
      clcd_pkg::ST_EMIT: begin
        cmd.emit = slot_free;
        if (slot_free && stat.last) begin
          state_next = clcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = clcd_pkg::ST_IDLE;
      end
    endcase
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

>>> hdl/clcd_dp.sv
// datapath for the character lcd write sequencer
module clcd_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic [1:0]         operation,
  input  logic [15:0]        value,
  input  logic [2:0]         row,
  input  logic [5:0]         column,
  input  clcd_pkg::cmd_t     cmd,
  output clcd_pkg::stat_t    stat,
  output logic               reg_select,
  output logic               read_write,
  output logic               enable,
  output logic [7:0]         data_bus,
  output logic [1:0]         wait_ms,
  output logic               last_step
);

  logic        nibble_mode;
  logic        is_num;
  logic        rs;
  logic [7:0]  byte_reg;
  logic [15:0] num;
  logic [3:0]  digits [5];
  logic [2:0]  idx;
  logic [1:0]  phase;
  logic        half;

  logic [7:0]  row_offset;
  logic [7:0]  load_byte;
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot_x10;
  logic [3:0]  rem;
  logic [7:0]  cur_byte;
  logic [7:0]  step_data;
  logic        step_en;
  logic [1:0]  step_wait;

  // row offset for cursor moves; unknown rows give position 0
  always_comb begin
    case (row)
      3'd0:    row_offset = clcd_pkg::ROW0_OFFSET;
      3'd1:    row_offset = clcd_pkg::ROW1_OFFSET;
      3'd2:    row_offset = clcd_pkg::ROW2_OFFSET;
      3'd3:    row_offset = clcd_pkg::ROW3_OFFSET;
      default: row_offset = 8'h00;
    endcase
    case (operation)
      clcd_pkg::OP_CMD, clcd_pkg::OP_CHAR: load_byte = value[7:0];
      clcd_pkg::OP_CURSOR: begin
        if (row > 3'd3) begin
          load_byte = clcd_pkg::SET_ADDR_CMD;
        end else begin
          load_byte = (row_offset + {2'b00, column}) | clcd_pkg::SET_ADDR_CMD;
        end
      end
      default: load_byte = 8'h00;
    endcase
  end

  // digit extraction
  assign prod     = num * clcd_pkg::RECIP_TEN;
  assign quot     = prod[31:clcd_pkg::RECIP_SHIFT];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = 4'(num - quot_x10);
  assign stat.conv_done = (quot == 13'd0);

  // current step
  always_comb begin
    cur_byte = is_num ? {clcd_pkg::ASCII_DIGIT_HI, digits[idx]} : byte_reg;
    if (!nibble_mode) begin
      step_data = cur_byte;
    end else if (half) begin
      step_data = {cur_byte[3:0], 4'b0000};
    end else begin
      step_data = {cur_byte[7:4], 4'b0000};
    end
    step_en = (phase != clcd_pkg::PH_LOW);
    if (phase == clcd_pkg::PH_SETUP) begin
      step_wait = clcd_pkg::WAIT_NONE;
    end else if (nibble_mode && rs) begin
      step_wait = clcd_pkg::WAIT_LONG;
    end else begin
      step_wait = clcd_pkg::WAIT_SHORT;
    end
  end

  assign stat.last = (phase == clcd_pkg::PH_HIGH) && (!nibble_mode || half) &&
                     (!is_num || idx == 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_mode <= 1'b1;
    end else if (cfg_we) begin
      nibble_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_num   <= (operation == clcd_pkg::OP_NUM);
      rs       <= (operation == clcd_pkg::OP_CHAR) || (operation == clcd_pkg::OP_NUM);
      byte_reg <= load_byte;
      num      <= value;
      idx      <= 3'd0;
      phase    <= clcd_pkg::PH_SETUP;
      half     <= 1'b0;
    end
    if (cmd.conv) begin
      digits[idx] <= rem;
      num         <= {3'b000, quot};
      if (quot != 13'd0) begin
        idx <= idx + 3'd1;
      end
    end
    if (cmd.emit) begin
      reg_select <= rs;
      read_write <= 1'b0;
      enable     <= step_en;
      data_bus   <= step_data;
      wait_ms    <= step_wait;
      last_step  <= stat.last;
      if (phase != clcd_pkg::PH_HIGH) begin
        phase <= phase + 2'd1;
      end else begin
        phase <= clcd_pkg::PH_SETUP;
        if (nibble_mode && !half) begin
          half <= 1'b1;
        end else begin
          half <= 1'b0;
          if (idx != 3'd0) begin
            idx <= idx - 3'd1;
          end
        end
      end
    end
  end

endmodule

>>> hdl/char_lcd_write_sequencer_top.sv
// top level of the character lcd write sequencer
//
//  channel | handshake              | carries
//  --------+------------------------+-----------------------------------------------
//  in      | in_valid / in_ready    | operation, value, row, column
//  out     | out_valid / out_ready  | reg_select, read_write, enable, data_bus,
//          |                        | wait_ms, last_step
//  cfg     | cfg_we                 | cfg_wdata (nibble_mode)
//
// a request is accepted while idle, then for numbers one decimal digit is converted per cycle
// (1..5 digits, set by the divide-by-ten unit), then one pin step is emitted per cycle
// while out_ready is held high (3 or 6 steps per byte, up to 30)
// rst is synchronous active high; it empties the output register and sets nibble_mode
// a stalled out_ready freezes the step sequencer with the step held in the output register
// in_ready is high only between requests
module char_lcd_write_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] value,
  input  logic [2:0]  row,
  input  logic [5:0]  column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reg_select,
  output logic        read_write,
  output logic        enable,
  output logic [7:0]  data_bus,
  output logic [1:0]  wait_ms,
  output logic        last_step
);

  // command and status between controller and datapath
  clcd_pkg::cmd_t  cmd;
  clcd_pkg::stat_t stat;

  // sequencing: idle, digit conversion, step emission
  clcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // request registers, digit store, pulse counters and output register
  clcd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .operation  (operation),
    .value      (value),
    .row        (row),
    .column     (column),
    .cmd        (cmd),
    .stat       (stat),
    .reg_select (reg_select),
    .read_write (read_write),
    .enable     (enable),
    .data_bus   (data_bus),
    .wait_ms    (wait_ms),
    .last_step  (last_step)
  );

endmodule

>>> hdl/clcd_checker.sv
// port-level checks for the character lcd write sequencer
module clcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       read_write,
  input logic       enable,
  input logic [7:0] data_bus,
  input logic [1:0] wait_ms,
  input logic       last_step
);

  // a held step stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_bus) && $stable(wait_ms))
    else $error("output step changed while stalled");

  a_write_only: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> read_write == 1'b0)
    else $error("read_write not low");

  // data setup step has enable high
  a_setup_en: assert property (@(posedge clk) disable iff (rst)
    out_valid && wait_ms == 2'd0 |-> enable)
    else $error("zero-hold step without enable");

  // a run ends on an enable-high step with a hold
  a_last_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_step |-> enable && wait_ms != 2'd0)
    else $error("bad final step");

  // a new request is not taken right after one is
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

endmodule

bind char_lcd_write_sequencer_top clcd_checker u_clcd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_write (read_write),
  .enable     (enable),
  .data_bus   (data_bus),
  .wait_ms    (wait_ms),
  .last_step  (last_step)
);

>>> bench/tb_char_lcd_write_sequencer_top.sv
// self-checking testbench for the character lcd write sequencer top level
module tb_char_lcd_write_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  // bus width selection values for the one config register
  localparam logic MODE_8BIT = 1'b0;
  localparam logic MODE_4BIT = 1'b1;

  // generous bound, far above the slowest legal run
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 6;
  localparam int RAND_PER_PHASE = 66;
  localparam int DIR_ROWS = 24;
  localparam int DRAIN_CYCLES = 50;

  // one request as it goes into the block
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] val;
    logic [2:0]  row;
    logic [5:0]  col;
  } req_t;

  // one pin step as it comes out of the block
  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [7:0] data;
    logic [1:0] hold;
    logic       last;
  } step_t;

  // directed row: bus mode to run in, the request, and an optional
  // hand-written byte (single-byte runs only) that replaces the predictor
  typedef struct packed {
    logic       nib;
    req_t       req;
    logic       typed;
    logic       exp_rs;
    logic [7:0] exp_byte;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = '0;
  logic [15:0] value = '0;
  logic [2:0]  row = '0;
  logic [5:0]  column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        reg_select;
  logic        read_write;
  logic        enable;
  logic [7:0]  data_bus;
  logic [1:0]  wait_ms;
  logic        last_step;

  // pin steps still owed by the block, oldest first
  step_t pending_steps[$];
  // bus mode as the predictor sees it, follows every config write
  logic  nibble_mode_q = MODE_4BIT;
  int    error_count = 0;
  int    cycle_count = 0;
  // per-item idle draw limits for sender and receiver
  int    max_gap_in = 16;
  int    max_gap_out = 16;
  // when set, the receiver drops ready for this many cycles once
  int    hold_off_len = 0;

  dir_row_t directed_rows [DIR_ROWS];

  char_lcd_write_sequencer_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .value      (value),
    .row        (row),
    .column     (column),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reg_select (reg_select),
    .read_write (read_write),
    .enable     (enable),
    .data_bus   (data_bus),
    .wait_ms    (wait_ms),
    .last_step  (last_step)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog, a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one enable pulse: setup with enable high, then low, then high again
  function automatic void queue_pulse(logic rs, logic [7:0] d, logic [1:0] hold,
                                      logic is_last);
    pending_steps.push_back(step_t'{rs, 1'b0, 1'b1, d, clcd_pkg::WAIT_NONE, 1'b0});
    pending_steps.push_back(step_t'{rs, 1'b0, 1'b0, d, hold, 1'b0});
    pending_steps.push_back(step_t'{rs, 1'b0, 1'b1, d, hold, is_last});
  endfunction

  // one byte on the bus: a single pulse in 8-bit mode, high then low nibble
  // on d7..d4 in 4-bit mode, where characters get the longer hold
  function automatic void queue_byte_transfer(logic rs, logic [7:0] b, logic is_last);
    logic [1:0] hold;
    hold = (nibble_mode_q == MODE_4BIT && rs) ? clcd_pkg::WAIT_LONG : clcd_pkg::WAIT_SHORT;
    if (nibble_mode_q == MODE_4BIT) begin
      queue_pulse(rs, b & 8'hF0, hold, 1'b0);
      queue_pulse(rs, {b[3:0], 4'h0}, hold, is_last);
    end else begin
      queue_pulse(rs, b, hold, is_last);
    end
  endfunction

  // expected pin steps of one accepted request
  function automatic void predict_pin_steps(req_t r);
    logic [7:0]  pos;
    logic [15:0] num;
    logic [3:0]  digits [5];
    int          n;
    case (r.op)
      clcd_pkg::OP_CMD: queue_byte_transfer(1'b0, r.val[7:0], 1'b1);
      clcd_pkg::OP_CHAR: queue_byte_transfer(1'b1, r.val[7:0], 1'b1);
      clcd_pkg::OP_CURSOR: begin
        // ddram address of the row start plus column, rows past 3 go home
        case (r.row)
          3'd0: pos = {2'b00, r.col};
          3'd1: pos = {2'b00, r.col} + 8'h40;
          3'd2: pos = {2'b00, r.col} + 8'h14;
          3'd3: pos = {2'b00, r.col} + 8'h54;
          default: pos = 8'h00;
        endcase
        queue_byte_transfer(1'b0, pos | 8'h80, 1'b1);
      end
      default: begin
        // decimal digits, least significant first; zero still gives one digit
        num = r.val;
        n = 0;
        do begin
          digits[n] = 4'(num % 16'd10);
          num = num / 16'd10;
          n++;
        end while (num != 16'd0);
        for (int i = n - 1; i >= 0; i--) begin
          queue_byte_transfer(1'b1, {4'h3, digits[i]}, i == 0);
        end
      end
    endcase
  endfunction

  function automatic void report_step_error(string what, step_t want, step_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected rs=%b rw=%b en=%b data=%h wait=%0d last=%b",
               $realtime, what, want.rs, want.rw, want.en, want.data, want.hold, want.last);
      $display("%0t: %s:   actual rs=%b rw=%b en=%b data=%h wait=%0d last=%b",
               $realtime, what, got.rs, got.rw, got.en, got.data, got.hold, got.last);
    end
  endfunction

  // output monitor, every accepted step is matched against the oldest one owed
  always @(posedge clk) begin
    step_t got;
    step_t want;
    got = step_t'{reg_select, read_write, enable, data_bus, wait_ms, last_step};
    if (!rst && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        report_step_error("unexpected step", '0, got);
      end else begin
        want = pending_steps.pop_front();
        if (got.rs !== want.rs || got.rw !== want.rw || got.en !== want.en ||
            got.data !== want.data || got.hold !== want.hold || got.last !== want.last) begin
          report_step_error("step mismatch", want, got);
        end
      end
    end
  end

  // receiver: random stall before each step, plus one long hold-off on request
  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end
      stall = $urandom_range(0, max_gap_out);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // offer one request after a random gap, return at the accepting edge
  task automatic send_request(req_t r);
    int gap;
    gap = $urandom_range(0, max_gap_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= r.op;
    value     <= r.val;
    row       <= r.row;
    column    <= r.col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // config write, only once every owed step has come out
  task automatic set_mode(logic m);
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    nibble_mode_q = m;
  endtask

  // random request; number values are spread over every digit count and
  // columns mostly stay on the visible area with some past it
  function automatic req_t random_request();
    req_t r;
    r.op = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: r.val = 16'($urandom_range(0, 9));
      1: r.val = 16'($urandom_range(10, 999));
      2: r.val = 16'($urandom_range(1000, 65535));
      default: r.val = 16'($urandom_range(0, 65535));
    endcase
    r.row = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) begin
      r.col = 6'($urandom_range(40, 63));
    end else begin
      r.col = 6'($urandom_range(0, 39));
    end
    return r;
  endfunction

  initial begin : stimulus
    req_t r;

    // directed rows; typed bytes are the ones readable straight off the rules:
    // ignored upper value bits, unknown rows going home, the lone zero digit
    directed_rows = '{
      // 4-bit mode, straight out of reset
      '{MODE_4BIT, '{clcd_pkg::OP_CMD,    16'h0000, 3'd0, 6'd0},  1'b1, 1'b0, 8'h00},
      '{MODE_4BIT, '{clcd_pkg::OP_CMD,    16'hFFFF, 3'd7, 6'd63}, 1'b1, 1'b0, 8'hFF},
      '{MODE_4BIT, '{clcd_pkg::OP_CHAR,   16'h00A5, 3'd0, 6'd0},  1'b0, 1'b0, 8'h00},
      '{MODE_4BIT, '{clcd_pkg::OP_CHAR,   16'hFF5A, 3'd0, 6'd0},  1'b1, 1'b1, 8'h5A},
      '{MODE_4BIT, '{clcd_pkg::OP_CURSOR, 16'h0000, 3'd0, 6'd0},  1'b1, 1'b0, 8'h80},
      '{MODE_4BIT, '{clcd_pkg::OP_CURSOR, 16'h0000, 3'd1, 6'd39}, 1'b0, 1'b0, 8'h00},
      '{MODE_4BIT, '{clcd_pkg::OP_CURSOR, 16'hFFFF, 3'd2, 6'd63}, 1'b0, 1'b0, 8'h00},
      '{MODE_4BIT, '{clcd_pkg::OP_CURSOR, 16'h0000, 3'd3, 6'd63}, 1'b0, 1'b0, 8'h00},
      '{MODE_4BIT, '{clcd_pkg::OP_CURSOR, 16'h0000, 3'd7, 6'd63}, 1'b1, 1'b0, 8'h80},
      '{MODE_4BIT, '{clcd_pkg::OP_CURSOR, 16'h0000, 3'd4, 6'd21}, 1'b1, 1'b0, 8'h80},
      '{MODE_4BIT, '{clcd_pkg::OP_NUM,    16'd0,    3'd0, 6'd0},  1'b1, 1'b1, 8'h30},
      '{MODE_4BIT, '{clcd_pkg::OP_NUM,    16'd65535, 3'd0, 6'd0}, 1'b0, 1'b0, 8'h00},
      '{MODE_4BIT, '{clcd_pkg::OP_NUM,    16'd9,    3'd0, 6'd0},  1'b1, 1'b1, 8'h39},
      '{MODE_4BIT, '{clcd_pkg::OP_NUM,    16'd10,   3'd0, 6'd0},  1'b0, 1'b0, 8'h00},
      // 8-bit mode
      '{MODE_8BIT, '{clcd_pkg::OP_CMD,    16'h00FF, 3'd0, 6'd0},  1'b1, 1'b0, 8'hFF},
      '{MODE_8BIT, '{clcd_pkg::OP_CMD,    16'h5500, 3'd0, 6'd0},  1'b1, 1'b0, 8'h00},
      '{MODE_8BIT, '{clcd_pkg::OP_CHAR,   16'h0041, 3'd0, 6'd0},  1'b1, 1'b1, 8'h41},
      '{MODE_8BIT, '{clcd_pkg::OP_CURSOR, 16'h0000, 3'd2, 6'd0},  1'b1, 1'b0, 8'h94},
      '{MODE_8BIT, '{clcd_pkg::OP_CURSOR, 16'h0000, 3'd5, 6'd63}, 1'b1, 1'b0, 8'h80},
      '{MODE_8BIT, '{clcd_pkg::OP_CURSOR, 16'h0000, 3'd3, 6'd39}, 1'b0, 1'b0, 8'h00},
      '{MODE_8BIT, '{clcd_pkg::OP_NUM,    16'd0,    3'd6, 6'd63}, 1'b1, 1'b1, 8'h30},
      '{MODE_8BIT, '{clcd_pkg::OP_NUM,    16'd65535, 3'd0, 6'd0}, 1'b0, 1'b0, 8'h00},
      '{MODE_8BIT, '{clcd_pkg::OP_NUM,    16'd40000, 3'd0, 6'd0}, 1'b0, 1'b0, 8'h00},
      '{MODE_8BIT, '{clcd_pkg::OP_NUM,    16'd12345, 3'd0, 6'd0}, 1'b0, 1'b0, 8'h00}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part, the first rows rely on the reset value of the mode
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].nib != nibble_mode_q) begin
        set_mode(directed_rows[i].nib);
      end
      send_request(directed_rows[i].req);
      if (directed_rows[i].typed) begin
        queue_byte_transfer(directed_rows[i].exp_rs, directed_rows[i].exp_byte, 1'b1);
      end else begin
        predict_pin_steps(directed_rows[i].req);
      end
    end

    // random phases, alternating bus mode:
    // phase 2 runs with no idling at all, phase 3 stalls the output for a
    // long stretch while requests keep coming back to back
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_mode((p % 2 == 0) ? MODE_8BIT : MODE_4BIT);
      max_gap_in  = (p == 2 || p == 3) ? 0 : 16;
      max_gap_out = (p == 2) ? 0 : 16;
      if (p == 3) begin
        hold_off_len = 400;
      end
      repeat (RAND_PER_PHASE) begin
        r = random_request();
        send_request(r);
        predict_pin_steps(r);
      end
    end

    // drain, then a few more cycles to catch stray steps
    in_valid <= 1'b0;
    max_gap_out = 16;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
